// ===== rtl/fwpr_pkg.sv =====
// ----------------------------------------------------------------------------
// fwpr_pkg
// Shared field widths, codes and controller/datapath bundles for the ring
// queue with front-prefix reversal.
// ----------------------------------------------------------------------------
`default_nettype none

package fwpr_pkg;

  localparam int ActionW = 2;
  localparam int ValueW  = 32;
  localparam int KW      = 5;
  localparam int CountW  = 5;
  localparam int StatusW = 2;

  typedef enum logic [ActionW-1:0] {
    ACT_ENQ = 2'd0,
    ACT_DEQ = 2'd1,
    ACT_REV = 2'd2,
    ACT_NOP = 2'd3
  } action_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_BADK  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    MEM_NONE,
    MEM_WR_ENQ,
    MEM_RD_LO,
    MEM_RD_HI,
    MEM_WR_LO,
    MEM_WR_HI,
    MEM_RD_FRONT,
    MEM_RD_REAR
  } mem_op_e;

  typedef struct packed {
    logic    load;
    logic    apply;
    logic    cap_tmp;
    logic    step;
    logic    cap_front;
    logic    cap_rear;
    logic    out_load;
    mem_op_e mem_op;
  } cmd_t;

  typedef struct packed {
    logic rev_go;
    logic pair_left;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/fwpr_if.sv =====
// ----------------------------------------------------------------------------
// fwpr_if
// Valid/ready channels for the action items and the result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface fwpr_in_if;
  logic                               valid;
  logic                               ready;
  logic [fwpr_pkg::ActionW-1:0]       action;
  logic signed [fwpr_pkg::ValueW-1:0] value;
  logic [fwpr_pkg::KW-1:0]            reverse_count;

  modport source (output valid, output action, output value, output reverse_count,
                  input ready);
  modport sink   (input valid, input action, input value, input reverse_count,
                  output ready);
endinterface

interface fwpr_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [fwpr_pkg::ValueW-1:0] front_value;
  logic signed [fwpr_pkg::ValueW-1:0] rear_value;
  logic [fwpr_pkg::CountW-1:0]        entry_count;
  logic [fwpr_pkg::StatusW-1:0]       status;

  modport source (output valid, output front_value, output rear_value,
                  output entry_count, output status, input ready);
  modport sink   (input valid, input front_value, input rear_value,
                  input entry_count, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/fwpr_ram.sv =====
// ----------------------------------------------------------------------------
// fwpr_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fwpr_ram #(
  parameter int Width = 32,
  parameter int Depth = 16,
  localparam int AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] addr_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/fwpr_ctrl.sv =====
// ----------------------------------------------------------------------------
// fwpr_ctrl
// Sequencer: applies one action, swaps reversal pairs through the ring
// memory, reads back front and rear, then hands the result over.
// ----------------------------------------------------------------------------
`default_nettype none

module fwpr_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire fwpr_pkg::sts_t sts_i,
  output fwpr_pkg::cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_APPLY,
    S_RD_LO,
    S_RD_HI,
    S_WR_LO,
    S_WR_HI,
    S_RD_FRONT,
    S_RD_REAR,
    S_CAP_REAR,
    S_FINISH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.mem_op  = fwpr_pkg::MEM_NONE;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load = in_valid_i;
        if (in_valid_i) state_d = S_APPLY;
      end
      S_APPLY: begin
        cmd_o.apply  = 1'b1;
        cmd_o.mem_op = fwpr_pkg::MEM_WR_ENQ;
        state_d      = sts_i.rev_go ? S_RD_LO : S_RD_FRONT;
      end
      S_RD_LO: begin
        cmd_o.mem_op = fwpr_pkg::MEM_RD_LO;
        state_d      = S_RD_HI;
      end
      S_RD_HI: begin
        cmd_o.mem_op  = fwpr_pkg::MEM_RD_HI;
        cmd_o.cap_tmp = 1'b1;
        state_d       = S_WR_LO;
      end
      S_WR_LO: begin
        cmd_o.mem_op = fwpr_pkg::MEM_WR_LO;
        state_d      = S_WR_HI;
      end
      S_WR_HI: begin
        cmd_o.mem_op = fwpr_pkg::MEM_WR_HI;
        cmd_o.step   = 1'b1;
        state_d      = sts_i.pair_left ? S_RD_LO : S_RD_FRONT;
      end
      S_RD_FRONT: begin
        cmd_o.mem_op = fwpr_pkg::MEM_RD_FRONT;
        state_d      = S_RD_REAR;
      end
      S_RD_REAR: begin
        cmd_o.mem_op    = fwpr_pkg::MEM_RD_REAR;
        cmd_o.cap_front = 1'b1;
        state_d         = S_CAP_REAR;
      end
      S_CAP_REAR: begin
        cmd_o.cap_rear = 1'b1;
        state_d        = S_FINISH;
      end
      S_FINISH: begin
        cmd_o.out_load = sts_i.out_free;
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/fwpr_dpath.sv =====
// ----------------------------------------------------------------------------
// fwpr_dpath
// Ring head pointer, entry count, reversal offsets, ring memory and the result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module fwpr_dpath #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire fwpr_pkg::cmd_t                      cmd_i,
  output fwpr_pkg::sts_t                           sts_o,
  input  wire logic [fwpr_pkg::ActionW-1:0]        action_i,
  input  wire logic signed [fwpr_pkg::ValueW-1:0]  value_i,
  input  wire logic [fwpr_pkg::KW-1:0]             reverse_count_i,
  input  wire logic                                out_ready_i,
  output logic                                     out_valid_o,
  output logic signed [fwpr_pkg::ValueW-1:0]       front_value_o,
  output logic signed [fwpr_pkg::ValueW-1:0]       rear_value_o,
  output logic [fwpr_pkg::CountW-1:0]              entry_count_o,
  output logic [fwpr_pkg::StatusW-1:0]             status_o
);

  localparam int IdxW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);
  localparam int SumW = CntW + 1;
  localparam int CmpW = (CntW > fwpr_pkg::KW) ? CntW : fwpr_pkg::KW;
  localparam int VW   = fwpr_pkg::ValueW;

  fwpr_pkg::action_e      action_q;
  logic [VW-1:0]          value_q;
  logic [fwpr_pkg::KW-1:0] k_q;

  logic [IdxW-1:0]        head_q;
  logic [CntW-1:0]        count_q;
  logic [CntW-1:0]        lo_q, hi_q;
  logic [WIDTH-1:0]       tmp_q;
  logic [VW-1:0]          front_q, rear_q;
  fwpr_pkg::status_e      status_q;

  logic                   out_valid_q;
  logic [VW-1:0]          out_front_q, out_rear_q;
  logic [CntW-1:0]        out_count_q;
  fwpr_pkg::status_e      out_status_q;

  logic                   full, empty;
  logic [CmpW-1:0]        k_ext, cnt_ext;
  logic [CntW-1:0]        rear_off;
  logic                   mem_en, mem_we;
  logic [IdxW-1:0]        mem_addr;
  logic [WIDTH-1:0]       mem_wdata, mem_rdata, enq_word;
  logic [VW-1:0]          rd_word;

  function automatic logic [IdxW-1:0] slot(input logic [IdxW-1:0] head,
                                           input logic [CntW-1:0] off);
    logic [SumW-1:0] sum;
    sum = SumW'(head) + SumW'(off);
    if (sum >= SumW'(DEPTH)) sum = sum - SumW'(DEPTH);
    return sum[IdxW-1:0];
  endfunction

  assign full     = (count_q == CntW'(DEPTH));
  assign empty    = (count_q == '0);
  assign k_ext    = CmpW'(k_q);
  assign cnt_ext  = CmpW'(count_q);
  assign rear_off = empty ? '0 : count_q - CntW'(1);

  generate
    if (WIDTH >= VW) begin : g_wide
      assign rd_word  = mem_rdata[VW-1:0];
      if (WIDTH > VW) begin : g_ext
        assign enq_word = {{(WIDTH-VW){value_q[VW-1]}}, value_q};
      end else begin : g_eq
        assign enq_word = value_q;
      end
    end else begin : g_narrow
      assign rd_word  = {{(VW-WIDTH){mem_rdata[WIDTH-1]}}, mem_rdata};
      assign enq_word = value_q[WIDTH-1:0];
    end
  endgenerate

  always_comb begin
    mem_en    = 1'b1;
    mem_we    = 1'b0;
    mem_addr  = head_q;
    mem_wdata = mem_rdata;
    unique case (cmd_i.mem_op)
      fwpr_pkg::MEM_NONE: mem_en = 1'b0;
      fwpr_pkg::MEM_WR_ENQ: begin
        mem_en    = (action_q == fwpr_pkg::ACT_ENQ) && !full;
        mem_we    = 1'b1;
        mem_addr  = slot(head_q, count_q);
        mem_wdata = enq_word;
      end
      fwpr_pkg::MEM_RD_LO: mem_addr = slot(head_q, lo_q);
      fwpr_pkg::MEM_RD_HI: mem_addr = slot(head_q, hi_q);
      fwpr_pkg::MEM_WR_LO: begin
        mem_we   = 1'b1;
        mem_addr = slot(head_q, lo_q);
      end
      fwpr_pkg::MEM_WR_HI: begin
        mem_we    = 1'b1;
        mem_addr  = slot(head_q, hi_q);
        mem_wdata = tmp_q;
      end
      fwpr_pkg::MEM_RD_FRONT: mem_addr = head_q;
      fwpr_pkg::MEM_RD_REAR:  mem_addr = slot(head_q, rear_off);
      default: mem_en = 1'b0;
    endcase
  end

  fwpr_ram #(
    .Width(WIDTH),
    .Depth(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .en_i   (mem_en),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  // Hold the item and the working registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q <= fwpr_pkg::action_e'(action_i);
      value_q  <= value_i;
      k_q      <= reverse_count_i;
    end
    if (cmd_i.apply) begin
      lo_q <= '0;
      hi_q <= CntW'(fwpr_pkg::KW'(k_q - fwpr_pkg::KW'(1)));
      unique case (action_q)
        fwpr_pkg::ACT_ENQ: status_q <= full ? fwpr_pkg::ST_FULL : fwpr_pkg::ST_OK;
        fwpr_pkg::ACT_DEQ: status_q <= empty ? fwpr_pkg::ST_EMPTY : fwpr_pkg::ST_OK;
        fwpr_pkg::ACT_REV: status_q <= (k_ext > cnt_ext) ? fwpr_pkg::ST_BADK
                                                         : fwpr_pkg::ST_OK;
        default:           status_q <= fwpr_pkg::ST_OK;
      endcase
    end
    if (cmd_i.step) begin
      lo_q <= lo_q + CntW'(1);
      hi_q <= hi_q - CntW'(1);
    end
    if (cmd_i.cap_tmp)   tmp_q   <= mem_rdata;
    if (cmd_i.cap_front) front_q <= rd_word;
    if (cmd_i.cap_rear)  rear_q  <= rd_word;
    if (cmd_i.out_load) begin
      out_front_q  <= empty ? '0 : front_q;
      out_rear_q   <= empty ? '0 : rear_q;
      out_count_q  <= count_q;
      out_status_q <= status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.apply) begin
        if (action_q == fwpr_pkg::ACT_ENQ && !full) begin
          count_q <= count_q + CntW'(1);
        end else if (action_q == fwpr_pkg::ACT_DEQ && !empty) begin
          head_q  <= slot(head_q, CntW'(1));
          count_q <= count_q - CntW'(1);
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.rev_go    = (action_q == fwpr_pkg::ACT_REV) && (k_ext > CmpW'(1))
                           && (k_ext <= cnt_ext);
  assign sts_o.pair_left = (SumW'(lo_q) + SumW'(2)) < SumW'(hi_q);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign front_value_o = out_front_q;
  assign rear_value_o  = out_rear_q;
  assign entry_count_o = fwpr_pkg::CountW'(out_count_q);
  assign status_o      = out_status_q;

endmodule

`default_nettype wire

// ===== rtl/fifo_with_prefix_reverse.sv =====
// A reversal of k entries that goes ahead swaps its pairs one after another
// through the single ring memory port: each swapped pair takes two reads and
// two writes. A new item is accepted only once the previous result has been
// loaded into the result register.
// Reset clears the head pointer, the entry count, the sequencer and the
// result valid; ring contents stay undefined until written.
// ----------------------------------------------------------------------------
// fifo_with_prefix_reverse
// Bounded ring queue of signed words with enqueue, dequeue and in-place
// reversal of the first k entries; each action returns front, rear, count
// and status.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_with_prefix_reverse #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fwpr_in_if.sink   in_if,
  fwpr_out_if.source out_if
);

  fwpr_pkg::cmd_t cmd;
  fwpr_pkg::sts_t sts;

  fwpr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_if.valid),
    .in_ready_o(in_if.ready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  fwpr_dpath #(
    .DEPTH(DEPTH),
    .WIDTH(WIDTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .action_i       (in_if.action),
    .value_i        (in_if.value),
    .reverse_count_i(in_if.reverse_count),
    .out_ready_i    (out_if.ready),
    .out_valid_o    (out_if.valid),
    .front_value_o  (out_if.front_value),
    .rear_value_o   (out_if.rear_value),
    .entry_count_o  (out_if.entry_count),
    .status_o       (out_if.status)
  );

endmodule

`default_nettype wire

// ===== rtl/fwpr_checker.sv =====
// ----------------------------------------------------------------------------
// fwpr_checker
// Port-level checks on the ring queue: handshake, sequencing and status
// against the reported count.
// ----------------------------------------------------------------------------
`default_nettype none

module fwpr_checker #(
  parameter int DEPTH = 16
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_i,
  input wire logic                          out_valid_i,
  input wire logic                          out_ready_i,
  input wire logic [fwpr_pkg::CountW-1:0]   entry_count_i,
  input wire logic [fwpr_pkg::StatusW-1:0]  status_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("item taken while previous item in flight");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == fwpr_pkg::ST_EMPTY) |-> (entry_count_i == '0))
    else $error("empty status with entries held");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == fwpr_pkg::ST_FULL)
      |-> (entry_count_i == fwpr_pkg::CountW'(DEPTH)))
    else $error("full status without full count");

endmodule

bind fifo_with_prefix_reverse fwpr_checker #(
  .DEPTH(DEPTH)
) u_fwpr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_if.valid),
  .in_ready_i   (in_if.ready),
  .out_valid_i  (out_if.valid),
  .out_ready_i  (out_if.ready),
  .entry_count_i(out_if.entry_count),
  .status_i     (out_if.status)
);

`default_nettype wire

// ===== bench/tb_fifo_with_prefix_reverse.sv =====
// ----------------------------------------------------------------------------
// tb_fifo_with_prefix_reverse
// Drives enqueue, dequeue, prefix-reverse and no-op items into the ring queue
// and mirrors the queue contents to predict the front, rear, count and status
// of every result. Directed corner items come first, then random fill/drain
// waves under four idle and stall mixes on the two channels.
// ----------------------------------------------------------------------------

module tb_fifo_with_prefix_reverse;

  import fwpr_pkg::*;

  localparam int QDepth    = 16;
  localparam int WaveItems = 475;
  localparam int TailWait  = 60;

  typedef struct packed {
    logic signed [ValueW-1:0] front_value;
    logic signed [ValueW-1:0] rear_value;
    logic [CountW-1:0]        entry_count;
    status_e                  status;
  } queue_view_t;

  class ring_mirror;
    logic [ValueW-1:0] slots [QDepth];
    int unsigned       head;
    int unsigned       held;
    queue_view_t       awaited [$];
    int unsigned       errors;

    function new();
      head   = 0;
      held   = 0;
      errors = 0;
    endfunction

    function int unsigned at(int unsigned offset);
      return (head + offset) % QDepth;
    endfunction

    function void apply_action(action_e act, logic [ValueW-1:0] val, logic [KW-1:0] k);
      queue_view_t       view;
      int unsigned       lo;
      int unsigned       hi;
      logic [ValueW-1:0] swap;
      view.status = ST_OK;
      case (act)
        ACT_ENQ: begin
          if (held >= QDepth) begin
            view.status = ST_FULL;
          end else begin
            slots[at(held)] = val;
            held++;
          end
        end
        ACT_DEQ: begin
          if (held == 0) begin
            view.status = ST_EMPTY;
          end else begin
            head = at(1);
            held--;
          end
        end
        ACT_REV: begin
          if (k > held) begin
            view.status = ST_BADK;
          end else if (k > 1) begin
            lo = 0;
            hi = k - 1;
            while (lo < hi) begin
              swap         = slots[at(lo)];
              slots[at(lo)] = slots[at(hi)];
              slots[at(hi)] = swap;
              lo++;
              hi--;
            end
          end
        end
        default: ;
      endcase
      view.front_value = (held == 0) ? '0 : slots[at(0)];
      view.rear_value  = (held == 0) ? '0 : slots[at(held - 1)];
      view.entry_count = held[CountW-1:0];
      awaited.push_back(view);
    endfunction

    function void match_result(queue_view_t got);
      queue_view_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result front %0d rear %0d count %0d status %0d", $time,
                 got.front_value, got.rear_value, got.entry_count, got.status);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got.front_value !== want.front_value) begin
        $display("%0t: front_value expected %0d got %0d", $time,
                 want.front_value, got.front_value);
        errors++;
      end
      if (got.rear_value !== want.rear_value) begin
        $display("%0t: rear_value expected %0d got %0d", $time,
                 want.rear_value, got.rear_value);
        errors++;
      end
      if (got.entry_count !== want.entry_count) begin
        $display("%0t: entry_count expected %0d got %0d", $time,
                 want.entry_count, got.entry_count);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  int   src_idle_pct;
  int   snk_stall_pct;
  bit   filling;

  ring_mirror mirror;

  fwpr_in_if  act_ch ();
  fwpr_out_if res_ch ();

  fifo_with_prefix_reverse dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (act_ch),
    .out_if (res_ch)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    res_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      mirror.match_result('{res_ch.front_value, res_ch.rear_value, res_ch.entry_count,
                            status_e'(res_ch.status)});
    end
  end

  task automatic push_item(action_e act, logic [ValueW-1:0] val, logic [KW-1:0] k);
    int gap;
    if ($urandom_range(99) < src_idle_pct) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(13, 45) : $urandom_range(1, 6);
      act_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    act_ch.valid         <= 1'b1;
    act_ch.action        <= act;
    act_ch.value         <= val;
    act_ch.reverse_count <= k;
    do @(posedge clk_i); while (!act_ch.ready);
    mirror.apply_action(act, val, k);
  endtask

  task automatic random_item();
    int                roll;
    action_e           act;
    logic [ValueW-1:0] val;
    logic [KW-1:0]     k;
    if (mirror.held == QDepth && $urandom_range(3) == 0) filling = 1'b0;
    if (mirror.held == 0 && $urandom_range(3) == 0) filling = 1'b1;
    if ($urandom_range(39) == 0) filling = ~filling;
    roll = $urandom_range(99);
    if (roll < 3) act = ACT_NOP;
    else if (roll < 25) act = ACT_REV;
    else if (roll < 80) act = filling ? ACT_ENQ : ACT_DEQ;
    else act = filling ? ACT_DEQ : ACT_ENQ;
    case ($urandom_range(9))
      0: val = 32'h8000_0000;
      1: val = 32'h7fff_ffff;
      2: val = '0;
      3: val = '1;
      default: val = $urandom;
    endcase
    if ($urandom_range(9) == 0) k = KW'($urandom_range(31));
    else k = KW'($urandom_range(mirror.held));
    push_item(act, val, k);
  endtask

  initial begin
    mirror               = new();
    src_idle_pct         = 0;
    snk_stall_pct        = 0;
    filling              = 1'b1;
    rst_ni               = 1'b0;
    act_ch.valid         <= 1'b0;
    act_ch.action        <= ACT_NOP;
    act_ch.value         <= '0;
    act_ch.reverse_count <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_item(ACT_DEQ, 32'h0, 5'd0);
    push_item(ACT_REV, 32'h0, 5'd0);
    push_item(ACT_REV, 32'h0, 5'd1);
    push_item(ACT_ENQ, 32'h8000_0000, 5'd0);
    push_item(ACT_ENQ, 32'h7fff_ffff, 5'd31);
    push_item(ACT_NOP, 32'h1234_5678, 5'd2);
    push_item(ACT_ENQ, 32'hffff_ffff, 5'd0);
    push_item(ACT_REV, 32'h0, 5'd4);
    push_item(ACT_REV, 32'h0, 5'd3);
    push_item(ACT_DEQ, 32'h0, 5'd0);
    repeat (QDepth - 2) push_item(ACT_ENQ, $urandom, 5'd0);
    push_item(ACT_ENQ, 32'h0, 5'd0);
    push_item(ACT_REV, 32'h0, 5'd16);
    push_item(ACT_DEQ, 32'h0, 5'd0);

    repeat (WaveItems) random_item();
    src_idle_pct = 68;
    repeat (WaveItems) random_item();
    src_idle_pct  = 0;
    snk_stall_pct = 68;
    repeat (WaveItems) random_item();
    src_idle_pct  = 37;
    snk_stall_pct = 37;
    repeat (WaveItems) random_item();

    act_ch.valid <= 1'b0;
    while (mirror.awaited.size() != 0) @(posedge clk_i);
    repeat (TailWait) @(posedge clk_i);
    if (mirror.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/fwpr_pkg.sv
rtl/fwpr_if.sv
rtl/fwpr_ram.sv
rtl/fwpr_ctrl.sv
rtl/fwpr_dpath.sv
rtl/fifo_with_prefix_reverse.sv
rtl/fwpr_checker.sv
bench/tb_fifo_with_prefix_reverse.sv
